/* hdl/shae_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the SHA-256 hash engine.
// No dependencies; every other file of the block but shae_ram uses it.
package shae_pkg;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // Control from the sequencer to the round datapath
    typedef struct packed {
        logic load_v;   // shift a hash word into the working variables
        logic round;    // run one compression round
        logic w_shift;  // advance the schedule window
        logic w_mem;    // next schedule word comes from the block memory
    } t_rnd_ctl;

    // Input transfer kinds
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam int unsigned BLK_WORDS = 16;
    localparam int unsigned HASH_WORDS = 8;

    localparam logic [7:0] PAD_MARK    = 8'h80;
    localparam logic [5:0] PAD_LEN_POS = 6'd56;
    localparam logic [5:0] BLK_LAST    = 6'd63;
    localparam logic [5:0] SCHED_MEM_END = 6'd15;

    localparam logic [31:0] SHAE_IV [HASH_WORDS] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] SHAE_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

/* hdl/shae_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module shae_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/shae_round.sv */
`timescale 1ns / 1ps
// Compression datapath: working variables a..h and the 16-word schedule window.
// Depends on shae_pkg.
module shae_round (
    input  logic               i_clk,
    input  shae_pkg::t_rnd_ctl i_ctl,
    input  logic [5:0]         i_t,
    input  logic [31:0]        i_mem_w,
    input  logic [31:0]        i_h_word,
    output logic [31:0]        o_v0
);
    import shae_pkg::*;

    logic [31:0] r_v [8];
    logic [31:0] r_w [16];   // r_w[15] is W(t), r_w[0] is W(t-15)
    logic [31:0] w_calc, w_in, s0, s1, ss0, ss1, ch, maj, t0, t1;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    always_comb begin
        s0     = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1     = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_calc = s1 + r_w[9] + s0 + r_w[0];
        w_in   = i_ctl.w_mem ? i_mem_w : w_calc;
        ss1    = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch     = r_v[6] ^ (r_v[4] & (r_v[5] ^ r_v[6]));
        t0     = r_v[7] + ss1 + ch + SHAE_K[i_t] + r_w[15];
        ss0    = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        maj    = (r_v[0] & r_v[1]) | (r_v[0] & r_v[2]) | (r_v[1] & r_v[2]);
        t1     = ss0 + maj;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_v) begin
            for (int j = 0; j < 7; j++) begin
                r_v[j] <= r_v[j+1];
            end
            r_v[7] <= i_h_word;
        end else if (i_ctl.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t0;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t0 + t1;
        end
        if (i_ctl.w_shift) begin
            for (int j = 0; j < 15; j++) begin
                r_w[j] <= r_w[j+1];
            end
            r_w[15] <= w_in;
        end
    end

    assign o_v0 = r_v[0];
endmodule

/* hdl/sha256_hash_engine.sv */
`timescale 1ns / 1ps
// SHA-256 hash engine top level: sequencer, byte packing, padding, hash state memory.
// Depends on shae_pkg, shae_ram, shae_round.
//
//  channel | valid   | stall    | payload
//  --------+---------+----------+-----------------------------
//  input   | i_valid | o_stall  | i_item  (kind, data_byte)
//  output  | o_valid | i_stall  | o_item  (digest_word, word_index, last_word)
//
// The engine takes message bytes while idle; the 64th byte of a block starts one
// compression (8 hash reads, 64 rounds, 8 add-and-write-backs of the hash words).
// Finish runs padding one byte per cycle, held while a compression runs, with a
// turn step before the length field, one or two compressions, then emits the 8
// words from the hash memory, each through a read state and an output-load state.
// Reset (synchronous, active low) clears the sequencer, byte count and the
// hash-word valid bits; an invalid hash entry reads as its initial value.
// The output register lets the last word wait while the next item is taken;
// a stall on the output while earlier words are pending holds the sequencer.
module sha256_hash_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  shae_pkg::t_in_item  i_item,
    output logic                o_stall,
    output logic                o_valid,
    input  logic                i_stall,
    output shae_pkg::t_out_item o_item
);
    import shae_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_LOADH, S_ROUND, S_ADD, S_EMIT_RD, S_EMIT_LD
    } t_state;

    typedef enum logic [1:0] {P_MARK, P_ZERO, P_LEN, P_DONE} t_pphase;

    t_state      r_state, n_state;
    t_pphase     r_pphase, n_pphase;
    logic        r_fin, n_fin;
    logic [5:0]  r_pos, n_pos;        // fill position within the block
    logic [60:0] r_count, n_count;    // message byte count, wraps at 2^61
    logic [63:0] r_bits, n_bits;      // bit length, shifted out MSB first
    logic [23:0] r_word, n_word;      // bytes gathered toward the next word
    logic [3:0]  r_k, n_k;
    logic [5:0]  r_t, n_t;
    logic [7:0]  r_hv, n_hv;          // hash entry written since last digest
    logic        r_h_rdv;
    logic [2:0]  r_h_rda;
    logic        r_ovalid, n_ovalid;
    t_out_item   r_oitem, n_oitem;

    logic        do_byte;
    logic [7:0]  byte_val;
    t_rnd_ctl    ctl;
    logic        h_we;
    logic [2:0]  h_waddr;
    logic [31:0] h_rdata, h_word, h_wdata, v0, b_rdata;
    logic [3:0]  b_raddr;

    assign h_word  = r_h_rdv ? h_rdata : SHAE_IV[r_h_rda];
    assign h_wdata = h_word + v0;
    assign h_waddr = r_k[2:0] - 3'd1;

    always_comb begin
        case (r_state)
            S_LOADH: b_raddr = (r_k == 4'd8) ? 4'd1 : 4'd0;
            S_ROUND: b_raddr = r_t[3:0] + 4'd2;
            default: b_raddr = 4'd0;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_pphase = r_pphase;
        n_fin    = r_fin;
        n_pos    = r_pos;
        n_count  = r_count;
        n_bits   = r_bits;
        n_word   = r_word;
        n_k      = r_k;
        n_t      = r_t;
        n_hv     = r_hv;
        n_ovalid = r_ovalid;
        n_oitem  = r_oitem;
        do_byte  = 1'b0;
        byte_val = 8'd0;
        ctl      = '0;
        h_we     = 1'b0;

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_item.kind == KIND_BYTE) begin
                        do_byte  = 1'b1;
                        byte_val = i_item.data_byte;
                        n_count  = r_count + 61'd1;
                    end else begin
                        n_fin    = 1'b1;
                        n_bits   = {r_count, 3'b000};
                        n_pphase = P_MARK;
                        n_state  = S_PAD;
                    end
                end
            end
            S_PAD: begin
                case (r_pphase)
                    P_MARK: begin
                        do_byte  = 1'b1;
                        byte_val = PAD_MARK;
                        n_pphase = P_ZERO;
                    end
                    P_ZERO: begin
                        if (r_pos == PAD_LEN_POS) begin
                            n_pphase = P_LEN;
                        end else begin
                            do_byte = 1'b1;
                        end
                    end
                    P_LEN: begin
                        do_byte  = 1'b1;
                        byte_val = r_bits[63:56];
                        n_bits   = r_bits << 8;
                        if (r_pos == BLK_LAST) begin
                            n_pphase = P_DONE;
                        end
                    end
                    default: ;
                endcase
            end
            S_LOADH: begin
                ctl.load_v = (r_k != 4'd0);
                if (r_k == 4'd8) begin
                    ctl.w_shift = 1'b1;
                    ctl.w_mem   = 1'b1;
                    n_t         = 6'd0;
                    n_state     = S_ROUND;
                end else begin
                    n_k = r_k + 4'd1;
                end
            end
            S_ROUND: begin
                ctl.round   = 1'b1;
                ctl.w_shift = 1'b1;
                ctl.w_mem   = (r_t < SCHED_MEM_END);
                n_t         = r_t + 6'd1;
                if (r_t == BLK_LAST) begin
                    n_k     = 4'd0;
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (r_k != 4'd0) begin
                    h_we          = 1'b1;
                    ctl.load_v    = 1'b1;
                    n_hv[h_waddr] = 1'b1;
                end
                if (r_k == 4'd8) begin
                    n_k = 4'd0;
                    if (!r_fin) begin
                        n_state = S_IDLE;
                    end else if (r_pphase == P_DONE) begin
                        n_state = S_EMIT_RD;
                    end else begin
                        n_state = S_PAD;
                    end
                end else begin
                    n_k = r_k + 4'd1;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_oitem  = '{digest_word: h_word, word_index: r_k[2:0],
                                 last_word: (r_k == 4'd7)};
                    if (r_k == 4'd7) begin
                        // digest out: back to the initial hash for the next message
                        n_hv    = '0;
                        n_fin   = 1'b0;
                        n_count = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 4'd1;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (do_byte) begin
            n_word = {r_word[15:0], byte_val};
            n_pos  = r_pos + 6'd1;
            if (r_pos == BLK_LAST) begin
                n_k     = 4'd0;
                n_state = S_LOADH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pphase <= P_MARK;
            r_fin    <= 1'b0;
            r_pos    <= '0;
            r_count  <= '0;
            r_k      <= '0;
            r_t      <= '0;
            r_hv     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pphase <= n_pphase;
            r_fin    <= n_fin;
            r_pos    <= n_pos;
            r_count  <= n_count;
            r_k      <= n_k;
            r_t      <= n_t;
            r_hv     <= n_hv;
            r_ovalid <= n_ovalid;
        end
        r_bits  <= n_bits;
        r_word  <= n_word;
        r_oitem <= n_oitem;
        r_h_rdv <= r_hv[r_k[2:0]];
        r_h_rda <= r_k[2:0];
    end

    shae_ram #(.WIDTH(32), .DEPTH(BLK_WORDS)) u_blk_ram (
        .i_clk   (i_clk),
        .i_we    (do_byte && (r_pos[1:0] == 2'd3)),
        .i_waddr (r_pos[5:2]),
        .i_wdata ({r_word, byte_val}),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    shae_ram #(.WIDTH(32), .DEPTH(HASH_WORDS)) u_hash_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (r_k[2:0]),
        .o_rdata (h_rdata)
    );

    shae_round u_round (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_t      (r_t),
        .i_mem_w  (b_rdata),
        .i_h_word (h_word),
        .o_v0     (v0)
    );

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_item  = r_oitem;
endmodule

/* hdl/shae_check.sv */
`timescale 1ns / 1ps
// Port-level checker for the SHA-256 hash engine, bound to the top level.
// Depends on shae_pkg.
module shae_check (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input shae_pkg::t_in_item  i_item,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input shae_pkg::t_out_item o_item
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("output transfer changed while stalled");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.last_word == (o_item.word_index == 3'd7)))
        else $error("last_word does not match word_index");

    a_busy_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item.last_word |-> o_stall)
        else $error("input taken while digest words still pending");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.last_word && !i_stall |=> !o_valid)
        else $error("output right after final digest word");
endmodule

bind sha256_hash_engine shae_check u_shae_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .i_item  (i_item),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);

/* dv/sha256_hash_engine_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the SHA-256 hash engine: random byte streams with finish
// transfers, digests predicted in a scoreboard class. Depends on shae_pkg and the RTL.
module sha256_hash_engine_tb;
    import shae_pkg::*;

    localparam int WDOG_LIMIT = 20000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    t_in_item  i_item;
    logic      o_stall;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_item;

    int n_err;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_recv;
    bit done;
    int quiet_cycles;

    task automatic report_err(string msg);
        n_err++;
        if (n_err <= 50) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Scoreboard: software SHA-256 of the bytes seen so far, queue of digest words
    class digest_board;
        logic [31:0] hs [8];
        logic [7:0]  blk [64];
        logic [60:0] nbytes;
        t_out_item   pending [$];

        function new();
            hs = SHAE_IV;
            nbytes = '0;
        endfunction

        function logic [31:0] rr(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] t0, t1, a, e;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            for (int i = 16; i < 64; i++)
                w[i] = (rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                     + (rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
            v = hs;
            for (int i = 0; i < 64; i++) begin
                a = v[0];
                e = v[4];
                t0 = v[7] + (rr(e, 6) ^ rr(e, 11) ^ rr(e, 25)) + (v[6] ^ (e & (v[5] ^ v[6])))
                   + SHAE_K[i] + w[i];
                t1 = (rr(a, 2) ^ rr(a, 13) ^ rr(a, 22)) + ((a & v[1]) | (a & v[2]) | (v[1] & v[2]));
                for (int j = 7; j > 0; j--) v[j] = v[j-1];
                v[4] = v[4] + t0;
                v[0] = t0 + t1;
            end
            for (int i = 0; i < 8; i++) hs[i] += v[i];
        endfunction

        // note one accepted input transfer
        function void note_input(t_in_item it);
            int pos;
            logic [63:0] bits;
            t_out_item o;
            pos = nbytes[5:0];
            if (it.kind == KIND_BYTE) begin
                blk[pos] = it.data_byte;
                nbytes++;
                if (pos == 63) compress();
                return;
            end
            bits = {nbytes, 3'b000};
            blk[pos] = PAD_MARK;
            pos++;
            if (pos > 56) begin
                while (pos < 64) blk[pos++] = 8'h00;
                compress();
                pos = 0;
            end
            while (pos < 56) blk[pos++] = 8'h00;
            for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++) begin
                o.digest_word = hs[i];
                o.word_index = i[2:0];
                o.last_word = (i == 7);
                pending.push_back(o);
            end
            hs = SHAE_IV;
            nbytes = '0;
        endfunction

        // check one accepted output transfer
        task check_result(t_out_item got);
            t_out_item exp_w;
            if (pending.size() == 0) begin
                report_err($sformatf("unexpected word %h", got));
                return;
            end
            exp_w = pending.pop_front();
            if (got.digest_word !== exp_w.digest_word)
                report_err($sformatf("digest_word %h, want %h", got.digest_word,
                    exp_w.digest_word));
            if (got.word_index !== exp_w.word_index)
                report_err($sformatf("word_index %0d, want %0d", got.word_index,
                    exp_w.word_index));
            if (got.last_word !== exp_w.last_word)
                report_err($sformatf("last_word %b, want %b", got.last_word,
                    exp_w.last_word));
        endtask
    endclass

    digest_board sb;

    sha256_hash_engine u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Monitor: input and output transfers sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_input(i_item);
            if (o_valid && !i_stall) sb.check_result(o_item);
        end
    end

    // Receiver: random stall, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else if (hold_recv) i_stall <= 1'b1;
        else i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || hold_recv || !i_rst_n)
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT && !done) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // One input transfer; random gaps before it. Payload held while stalled.
    // Valid stays high on return so the next transfer can follow at once.
    task automatic send_item(logic kind, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item.kind <= kind;
        i_item.data_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_msg(int len, bit fixed, logic [7:0] fb);
        for (int i = 0; i < len; i++)
            send_item(KIND_BYTE, fixed ? fb : 8'($urandom));
        send_item(KIND_FINISH, 8'($urandom));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // Random messages: half short, the rest near or across one or two block boundaries
    task automatic random_phase(int budget);
        int sent;
        int len;
        sent = 0;
        while (sent < budget) begin
            case ($urandom_range(3))
                0: len = $urandom_range(0, 8);
                1: len = $urandom_range(50, 70);
                2: len = $urandom_range(110, 130);
                default: len = $urandom_range(0, 40);
            endcase
            // stray finish on an empty message now and then
            if ($urandom_range(9) == 0) send_item(KIND_FINISH, 8'($urandom));
            send_msg(len, 0, 8'h00);
            sent += len + 1;
        end
    endtask

    initial begin
        n_err = 0;
        done = 0;
        hold_recv = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        sb = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty message, finish data ignored, pad edges at 55/56/63/64
        send_item(KIND_FINISH, 8'hFF);
        send_item(KIND_FINISH, 8'h00);
        send_msg(3, 1, 8'hFF);
        send_msg(1, 1, 8'h00);
        send_msg(55, 0, 8'h00);
        send_msg(56, 0, 8'h00);
        send_msg(63, 1, 8'hA5);
        send_msg(64, 1, 8'h5A);
        drain();

        // Long receiver hold-off while bytes keep coming
        fork
            begin
                hold_recv <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_recv <= 1'b0;
            end
            begin
                send_msg(2, 0, 8'h00);
                send_msg(5, 0, 8'h00);
                send_msg(10, 0, 8'h00);
            end
        join
        drain();

        send_idle_pct = 9;
        recv_idle_pct = 59;
        random_phase(40);
        drain();
        send_idle_pct = 59;
        recv_idle_pct = 9;
        random_phase(40);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(40);
        drain();

        repeat (200) @(posedge i_clk);
        done = 1;
        if (n_err == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/shae_pkg.sv
hdl/shae_ram.sv
hdl/shae_round.sv
hdl/sha256_hash_engine.sv
hdl/shae_check.sv
dv/sha256_hash_engine_tb.sv
